[rtl/mma_pkg.sv]
// Shared types and constants of the multichannel moving-average block.
// Used by mma_cell, mma_chan and multichannel_moving_average; depends on nothing.
`default_nettype none

package mma_pkg;

  // Window length in scans and number of active channels.
  localparam int WINDOW   = 8;
  localparam int CHANNELS = 8;

  // Fixed shape of one scan and one result on the stream ports.
  localparam int FIELDS   = 8;
  localparam int SAMPLE_W = 12;
  localparam int TDATA_W  = FIELDS * SAMPLE_W;

  // Fill counter width and width of a per-channel running sum.
  localparam int CNT_W = $clog2(WINDOW);
  localparam int SUM_W = SAMPLE_W + CNT_W;

  // Division by WINDOW is done as a multiply by a rounded-up reciprocal.
  // With the shift set to SUM_W + CNT_W the quotient is exact for every sum.
  localparam int REC_SHIFT = SUM_W + CNT_W;
  localparam int REC_W     = SUM_W + 1;
  localparam int PROD_W    = SUM_W + REC_W;
  localparam logic [REC_W-1:0] REC_MULT =
    REC_W'(((64'd1 << REC_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef sample_t [CHANNELS-1:0] scan_t;

  // Control for the per-channel accumulators.
  typedef struct packed {
    logic load;  // a scan was taken: update the running sum
    logic drop;  // the window is full: remove the oldest sample
  } acc_ctl_t;

endpackage

`default_nettype wire

[rtl/mma_cell.sv]
// One cell of the scan delay line: holds one scan and passes it on.
// Depends on mma_pkg.
`default_nettype none

module mma_cell (
  input  wire logic          clk,
  input  wire logic          shift,
  input  wire mma_pkg::scan_t d,
  output      mma_pkg::scan_t q
);

  mma_pkg::scan_t scan_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      scan_r <= d;
    end
  end

  assign q = scan_r;

endmodule

`default_nettype wire

[rtl/mma_chan.sv]
// Running sum of one channel and its division by the window length.
// Depends on mma_pkg.
`default_nettype none

module mma_chan (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mma_pkg::acc_ctl_t ctl,
  input  wire mma_pkg::sample_t  add,
  input  wire mma_pkg::sample_t  sub,
  output      mma_pkg::sample_t  mean
);

  mma_pkg::sum_t                   sum_r;
  mma_pkg::sum_t                   sum_nxt;
  mma_pkg::sum_t                   sub_ext;
  logic [mma_pkg::PROD_W-1:0]      prod;

  assign sub_ext = ctl.drop ? mma_pkg::SUM_W'(sub) : '0;
  assign sum_nxt = sum_r - sub_ext + mma_pkg::SUM_W'(add);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.load) begin
      sum_r <= sum_nxt;
    end
  end

  // The true sum never exceeds WINDOW * 4095, so the quotient fits 12 bits.
  assign prod = mma_pkg::PROD_W'(sum_r) * mma_pkg::PROD_W'(mma_pkg::REC_MULT);
  assign mean = prod[mma_pkg::REC_SHIFT +: mma_pkg::SAMPLE_W];

endmodule

`default_nettype wire

[rtl/multichannel_moving_average.sv]
// Multichannel moving average: per-channel truncated mean over the last WINDOW scans.
// Throughput: one scan per cycle unless a result in the sums waits behind a stalled output.
// Latency: the accepting edge updates the running sums; the output register then loads their
// quotient once it is free, and out_tvalid rises with it.
// The first WINDOW-1 scans after reset give no result; the delay line needs no clearing.
// Reset (rst_n low, synchronous) clears the running sums, fill count and valid flags.
// Depends on mma_pkg, mma_cell and mma_chan.
`default_nettype none

module multichannel_moving_average (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input scans.
  input  wire logic                        in_tvalid,
  output      logic                        in_tready,
  input  wire logic [mma_pkg::TDATA_W-1:0] in_tdata,   // sample_ch0 .. sample_ch7, 12 bits each
  // Window means.
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  output      logic [mma_pkg::TDATA_W-1:0] out_tdata   // mean_ch0 .. mean_ch7, 12 bits each
);

  // The scans travel down a row of cells, one cell per scan of the window.
  // Cell 0 takes the newest scan; the last cell holds the oldest, which is
  // the one dropped from the running sums once the window is full.
  mma_pkg::scan_t chain [mma_pkg::WINDOW+1];

  logic              in_acc;      // input transaction at this edge
  logic              out_free;    // the output register can take a new result
  logic              full_r;      // WINDOW scans have been seen
  logic              full_nxt;
  mma_pkg::cnt_t     cnt_r;       // scans seen while filling
  logic              m_valid_r;   // the running sums hold a result not yet sent
  logic              m_valid_nxt;
  logic              out_valid_r;
  mma_pkg::acc_ctl_t acc_ctl;
  mma_pkg::sample_t  mean   [mma_pkg::CHANNELS];
  mma_pkg::sample_t  mean_r [mma_pkg::CHANNELS];

  // Handshake. A result waiting in the output register does not block the
  // input: the sums are a second stage, so a scan is taken whenever the
  // sums are free or their result moves to the output in the same cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !m_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // Unpack the incoming transaction into the head of the chain.
  for (genvar c = 0; c < mma_pkg::CHANNELS; c++) begin : g_unpack
    assign chain[0][c] = in_tdata[c*mma_pkg::SAMPLE_W +: mma_pkg::SAMPLE_W];
  end

  for (genvar k = 0; k < mma_pkg::WINDOW; k++) begin : g_cell
    mma_cell u_cell (
      .clk   (clk),
      .shift (in_acc),
      .d     (chain[k]),
      .q     (chain[k+1])
    );
  end

  // Fill tracking: the scan that completes the window gives the first result.
  assign full_nxt = full_r || (cnt_r == mma_pkg::CNT_W'(mma_pkg::WINDOW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      full_r <= 1'b0;
    end else if (in_acc && !full_r) begin
      cnt_r  <= cnt_r + 1'b1;
      full_r <= full_nxt;
    end
  end

  // The oldest scan is only subtracted once every cell has been written.
  assign acc_ctl.load = in_acc;
  assign acc_ctl.drop = full_r;

  for (genvar c = 0; c < mma_pkg::CHANNELS; c++) begin : g_chan
    mma_chan u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (acc_ctl),
      .add   (chain[0][c]),
      .sub   (chain[mma_pkg::WINDOW][c]),
      .mean  (mean[c])
    );
  end

  // Result valid for the current sums.
  always_comb begin
    m_valid_nxt = m_valid_r;
    if (in_acc) begin
      m_valid_nxt = full_nxt;
    end else if (out_free) begin
      m_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      m_valid_r <= m_valid_nxt;
      if (out_free) begin
        out_valid_r <= m_valid_r;
      end
    end
  end

  // Output register: loads the quotient of the sums as they leave.
  always_ff @(posedge clk) begin
    if (out_free && m_valid_r) begin
      mean_r <= mean;
    end
  end

  assign out_tvalid = out_valid_r;

  // Channels above CHANNELS read as zero.
  for (genvar c = 0; c < mma_pkg::FIELDS; c++) begin : g_pack
    if (c < mma_pkg::CHANNELS) begin : g_used
      assign out_tdata[c*mma_pkg::SAMPLE_W +: mma_pkg::SAMPLE_W] = mean_r[c];
    end else begin : g_unused
      assign out_tdata[c*mma_pkg::SAMPLE_W +: mma_pkg::SAMPLE_W] = '0;
    end
  end

  // A result is only ever pending once the window has filled.
  a_result_needs_full : assert property (@(posedge clk) disable iff (!rst_n)
    m_valid_r |-> full_r)
    else $error("result pending before the window filled");

  // The window stays full until reset.
  a_full_sticks : assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("window full flag dropped");

  // While filling, each scan advances the fill count by one.
  a_fill_count : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !full_r && !full_nxt) |=> (cnt_r == $past(cnt_r + 1'b1)))
    else $error("fill count did not advance");

  // The sums are never overwritten while their result is stuck behind the output.
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!m_valid_r || out_free))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
